FILE: rtl/core/mmbc_pkg.sv
`default_nettype none

package mmbc_pkg;

    typedef enum logic [3:0] {
        ALG_ADLER32    = 4'd0,
        ALG_FLETCHER16 = 4'd1,
        ALG_FLETCHER32 = 4'd2,
        ALG_SUM8       = 4'd3,
        ALG_SUM16      = 4'd4,
        ALG_SUM32      = 4'd5,
        ALG_BSD        = 4'd6,
        ALG_XOR8       = 4'd7,
        ALG_SYSV       = 4'd8
    } algo_t;

    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [16:0] F32_MOD   = 17'd65535;
    localparam logic [8:0]  F16_MOD   = 9'd255;

    typedef struct packed {
        logic [31:0] low_sum;
        logic [15:0] high_sum;
    } sums_t;

    function automatic logic [31:0] start_low(input logic [3:0] algorithm);
        start_low = (algorithm == ALG_ADLER32) ? 32'd1 : 32'd0;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mmbc_update.sv
`default_nettype none

module mmbc_update (
    input  wire logic [3:0]      algorithm,
    input  wire mmbc_pkg::sums_t cur,
    input  wire logic [7:0]      data_byte,
    output mmbc_pkg::sums_t      nxt,
    output logic [31:0]          checksum
);

    logic [16:0] lo17;
    logic [16:0] hi17;
    logic [15:0] lo16;
    logic [15:0] hi16;
    logic [8:0]  lo9;
    logic [8:0]  hi9;
    logic [7:0]  lo8;
    logic [7:0]  hi8;
    logic [15:0] rot16;
    logic [31:0] sum32;
    logic [16:0] fold17;
    logic [15:0] fold16;

    always_comb
    begin
        lo17   = 17'd0;
        hi17   = 17'd0;
        lo16   = 16'd0;
        hi16   = 16'd0;
        lo9    = 9'd0;
        hi9    = 9'd0;
        lo8    = 8'd0;
        hi8    = 8'd0;
        rot16  = 16'd0;
        sum32  = 32'd0;
        fold17 = 17'd0;
        fold16 = 16'd0;
        nxt    = '0;
        checksum = 32'd0;
        case (algorithm)
            mmbc_pkg::ALG_ADLER32,
            mmbc_pkg::ALG_FLETCHER32:
            begin
                lo17 = {1'b0, cur.low_sum[15:0]} + {9'd0, data_byte};
                if (algorithm == mmbc_pkg::ALG_ADLER32)
                begin
                    lo16 = (lo17 >= mmbc_pkg::ADLER_MOD) ?
                           16'(lo17 - mmbc_pkg::ADLER_MOD) : lo17[15:0];
                    hi17 = {1'b0, cur.high_sum} + {1'b0, lo16};
                    hi16 = (hi17 >= mmbc_pkg::ADLER_MOD) ?
                           16'(hi17 - mmbc_pkg::ADLER_MOD) : hi17[15:0];
                end
                else
                begin
                    lo16 = (lo17 >= mmbc_pkg::F32_MOD) ?
                           16'(lo17 - mmbc_pkg::F32_MOD) : lo17[15:0];
                    hi17 = {1'b0, cur.high_sum} + {1'b0, lo16};
                    hi16 = (hi17 >= mmbc_pkg::F32_MOD) ?
                           16'(hi17 - mmbc_pkg::F32_MOD) : hi17[15:0];
                end
                nxt.low_sum  = {16'd0, lo16};
                nxt.high_sum = hi16;
                checksum     = {hi16, lo16};
            end
            mmbc_pkg::ALG_FLETCHER16:
            begin
                lo9 = {1'b0, cur.low_sum[7:0]} + {1'b0, data_byte};
                lo8 = (lo9 >= mmbc_pkg::F16_MOD) ? 8'(lo9 - mmbc_pkg::F16_MOD) : lo9[7:0];
                hi9 = {1'b0, cur.high_sum[7:0]} + {1'b0, lo8};
                hi8 = (hi9 >= mmbc_pkg::F16_MOD) ? 8'(hi9 - mmbc_pkg::F16_MOD) : hi9[7:0];
                nxt.low_sum  = {24'd0, lo8};
                nxt.high_sum = {8'd0, hi8};
                checksum     = {16'd0, hi8, lo8};
            end
            mmbc_pkg::ALG_SUM8:
            begin
                lo8 = cur.low_sum[7:0] + data_byte;
                nxt.low_sum = {24'd0, lo8};
                checksum    = {24'd0, lo8};
            end
            mmbc_pkg::ALG_SUM16:
            begin
                lo16 = cur.low_sum[15:0] + {8'd0, data_byte};
                nxt.low_sum = {16'd0, lo16};
                checksum    = {16'd0, lo16};
            end
            mmbc_pkg::ALG_SUM32:
            begin
                sum32 = cur.low_sum + {24'd0, data_byte};
                nxt.low_sum = sum32;
                checksum    = sum32;
            end
            mmbc_pkg::ALG_BSD:
            begin
                rot16 = {cur.low_sum[0], cur.low_sum[15:1]};
                lo16  = rot16 + {8'd0, data_byte};
                nxt.low_sum = {16'd0, lo16};
                checksum    = {16'd0, lo16};
            end
            mmbc_pkg::ALG_XOR8:
            begin
                lo8 = cur.low_sum[7:0] ^ data_byte;
                nxt.low_sum = {24'd0, lo8};
                checksum    = {24'd0, lo8};
            end
            mmbc_pkg::ALG_SYSV:
            begin
                sum32  = cur.low_sum + {24'd0, data_byte};
                fold17 = {1'b0, sum32[15:0]} + {1'b0, sum32[31:16]};
                fold16 = fold17[15:0] + {15'd0, fold17[16]};
                nxt.low_sum = sum32;
                checksum    = {16'd0, fold16};
            end
            default:
            begin
                nxt      = '0;
                checksum = 32'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/multi_mode_byte_checksum.sv
// Streaming byte checksum engine. One byte is taken per clock on the slave side, and the byte
// transfer marked by s_tlast closes the message: its checksum appears on m_tdata in the next
// cycle, zero-extended to 32 bits. The algorithm register selects 0 Adler-32, 1 Fletcher-16,
// 2 Fletcher-32, 3 sum8, 4 sum16, 5 sum32, 6 BSD, 7 XOR-8 or 8 System V; codes 9 to 15 give
// a checksum of zero. A write to the register restarts the message with the new algorithm's
// start values, so it should be done between messages. A single running-sum register pair is
// updated by every byte, so the next byte can follow at once; s_tready only drops while a
// finished checksum waits in the output register and m_tready is low.
`default_nettype none

module multi_mode_byte_checksum (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] checksum
);

    logic [3:0]      algorithm_reg;
    logic [3:0]      algorithm_next;
    mmbc_pkg::sums_t sums_reg;
    mmbc_pkg::sums_t sums_next;
    mmbc_pkg::sums_t upd_sums;
    logic [31:0]     upd_checksum;
    logic            m_tvalid_reg;
    logic            m_tvalid_next;
    logic [31:0]     m_tdata_reg;
    logic            s_accept;

    mmbc_update u_update (
        .algorithm (algorithm_reg),
        .cur       (sums_reg),
        .data_byte (s_tdata),
        .nxt       (upd_sums),
        .checksum  (upd_checksum)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        algorithm_next = algorithm_reg;
        sums_next      = sums_reg;
        if (cfg_wr_en)
        begin
            algorithm_next     = cfg_wr_data;
            sums_next.low_sum  = mmbc_pkg::start_low(cfg_wr_data);
            sums_next.high_sum = 16'd0;
        end
        else if (s_accept)
        begin
            if (s_tlast)
            begin
                sums_next.low_sum  = mmbc_pkg::start_low(algorithm_reg);
                sums_next.high_sum = 16'd0;
            end
            else
            begin
                sums_next = upd_sums;
            end
        end
        m_tvalid_next = (m_tvalid_reg && !m_tready) || (s_accept && s_tlast);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            algorithm_reg     <= mmbc_pkg::ALG_ADLER32;
            sums_reg.low_sum  <= 32'd1;
            sums_reg.high_sum <= 16'd0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            algorithm_reg <= algorithm_next;
            sums_reg      <= sums_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && s_tlast)
        begin
            m_tdata_reg <= upd_checksum;
        end
    end

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(s_accept && s_tlast))
        else $error("Checksum presented without a last byte transfer.");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (sums_reg.high_sum == 16'd0 &&
                       sums_reg.low_sum == mmbc_pkg::start_low(algorithm_reg)))
        else $error("Sums not at start values after algorithm write.");

    a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tlast && !cfg_wr_en) |=>
            (sums_reg.high_sum == 16'd0 &&
             sums_reg.low_sum == mmbc_pkg::start_low(algorithm_reg)))
        else $error("Sums not at start values after end of message.");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(m_tdata_reg)))
        else $error("Waiting checksum lost or changed.");

endmodule

`default_nettype wire
